FILE: rtl/imu_offset_scale_calibrator_macros.svh
// assertion macros for the imu offset and scale calibrator
`ifndef IMU_OFFSET_SCALE_CALIBRATOR_MACROS_SVH
`define IMU_OFFSET_SCALE_CALIBRATOR_MACROS_SVH

// same-cycle implication, checked outside reset
`define OSC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define OSC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/osc_pkg.sv
// shared types and constants of the imu offset and scale calibrator
package osc_pkg;

	localparam int SAMPLES = 1000;
	localparam int CNT_W   = 10;
	localparam int SMP_W   = 16;
	localparam int SUM_W   = 26;
	localparam int QW      = SMP_W + 1;

	localparam logic [CNT_W-1:0] SAMPLES_CNT = CNT_W'(SAMPLES);
	localparam logic [SUM_W-1:0] SAMPLES_SUM = SUM_W'(SAMPLES);

	// reciprocal for truncating division of a sum magnitude by the sample count
	localparam int DIV_SHIFT = SUM_W + 1;
	localparam int RECIP_W   = DIV_SHIFT + 1;
	localparam int PROD_W    = SUM_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << DIV_SHIFT) / SAMPLES);

	localparam int JQ_DEPTH  = 2;
	localparam int JQ_AW     = $clog2(JQ_DEPTH);
	localparam int RES_DEPTH = 4;
	localparam int RES_AW    = $clog2(RES_DEPTH);
	localparam int MAX_RES   = 3;

	localparam logic KIND_GYRO = 1'b0;
	localparam logic KIND_ACC  = 1'b1;

	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	typedef enum logic [2:0] {
		ST_WAIT1,
		ST_SUM1,
		ST_WAIT2,
		ST_SUM2,
		ST_EMIT
	} step_t;

	typedef struct packed {
		logic                    button_pressed;
		logic signed [SMP_W-1:0] sample_x;
		logic signed [SMP_W-1:0] sample_y;
		logic signed [SMP_W-1:0] sample_z;
	} in_t;

	typedef struct packed {
		logic                    result_kind;
		logic [1:0]              axis;
		logic signed [SMP_W-1:0] offset;
		logic signed [SMP_W-1:0] scale;
		logic                    last;
	} res_t;

	typedef struct packed {
		logic                    kind;
		logic [1:0]              axis;
		logic signed [SUM_W-1:0] sum0;
		logic signed [SUM_W-1:0] sum1;
		logic signed [SUM_W-1:0] sum2;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} jq_stat_t;

endpackage

FILE: rtl/osc_front.sv
// front end: calibration sequencer and per-axis accumulators
module osc_front import osc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	output logic     full,
	input  in_t      sample,
	input  logic     cfg_we,
	input  logic     cfg_wdata,
	input  jq_stat_t jq_stat,
	output logic     job_push,
	output job_t     job
);

	logic                    tgt_q;
	step_t                   step_q, step_d;
	logic [1:0]              axis_q, axis_d;
	logic [CNT_W-1:0]        cnt_q, cnt_d, cnt_inc;
	logic signed [SUM_W-1:0] sum_q [3];
	logic signed [SUM_W-1:0] sum_d [3];
	logic signed [SUM_W-1:0] sel;
	logic                    accept, press, cnt_done;

	assign full     = jq_stat.full;
	assign accept   = push && !jq_stat.full;
	assign press    = sample.button_pressed;
	assign cnt_inc  = cnt_q + 1'b1;
	assign cnt_done = (cnt_inc == SAMPLES_CNT);

	always_comb begin
		unique case (axis_q)
			AXIS_X:  sel = SUM_W'(sample.sample_x);
			AXIS_Y:  sel = SUM_W'(sample.sample_y);
			default: sel = SUM_W'(sample.sample_z);
		endcase
	end

	// next state
	always_comb begin
		step_d = step_q;
		axis_d = axis_q;
		unique case (step_q)
			ST_WAIT1: begin
				if (accept && press) step_d = ST_SUM1;
			end
			ST_SUM1: begin
				if (accept && cnt_done) step_d = tgt_q ? ST_WAIT2 : ST_EMIT;
			end
			ST_WAIT2: begin
				if (accept && press) step_d = ST_SUM2;
			end
			ST_SUM2: begin
				if (accept && cnt_done) begin
					step_d = ST_WAIT1;
					axis_d = (axis_q == AXIS_Z) ? AXIS_X : axis_q + 1'b1;
				end
			end
			ST_EMIT: begin
				if (accept) step_d = ST_WAIT1;
			end
			default: step_d = ST_WAIT1;
		endcase
		if (cfg_we) begin
			step_d = ST_WAIT1;
			axis_d = AXIS_X;
		end
	end

	// accumulators, counter and job hand-off
	always_comb begin
		cnt_d    = cnt_q;
		sum_d    = sum_q;
		job_push = 1'b0;
		job      = '{kind: tgt_q, axis: axis_q, sum0: sum_q[0], sum1: sum_q[1],
			sum2: sum_q[2]};
		if (accept) begin
			unique case (step_q)
				ST_WAIT1: begin
					if (press) begin
						cnt_d = '0;
						sum_d = '{default: '0};
					end
				end
				ST_SUM1: begin
					cnt_d = (cnt_done && tgt_q) ? '0 : cnt_inc;
					if (tgt_q) begin
						sum_d[0] = sum_q[0] + sel;
					end else begin
						sum_d[0] = sum_q[0] + SUM_W'(sample.sample_x);
						sum_d[1] = sum_q[1] + SUM_W'(sample.sample_y);
						sum_d[2] = sum_q[2] + SUM_W'(sample.sample_z);
					end
				end
				ST_SUM2: begin
					cnt_d    = cnt_done ? '0 : cnt_inc;
					sum_d[1] = sum_q[1] + sel;
					job.sum1 = sum_d[1];
					job_push = cnt_done;
				end
				ST_EMIT: begin
					job_push = 1'b1;
					cnt_d    = '0;
					sum_d    = '{default: '0};
				end
				default: ;
			endcase
		end
		if (cfg_we) begin
			cnt_d = '0;
			sum_d = '{default: '0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgt_q  <= 1'b0;
			step_q <= ST_WAIT1;
			axis_q <= AXIS_X;
			cnt_q  <= '0;
			sum_q  <= '{default: '0};
		end else begin
			if (cfg_we) tgt_q <= cfg_wdata;
			step_q <= step_d;
			axis_q <= axis_d;
			cnt_q  <= cnt_d;
			sum_q  <= sum_d;
		end
	end

endmodule

FILE: rtl/osc_jobq.sv
// two-entry queue of finished sums between front and back
module osc_jobq import osc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  job_t     din,
	input  logic     pop,
	output job_t     dout,
	output jq_stat_t stat
);

	job_t             mem [JQ_DEPTH];
	logic [JQ_AW-1:0] wr_q, rd_q;
	logic [JQ_AW:0]   cnt_q;

	assign dout       = mem[rd_q];
	assign stat.full  = (cnt_q == (JQ_AW+1)'(JQ_DEPTH));
	assign stat.empty = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (push) mem[wr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (JQ_AW+1)'(push) - (JQ_AW+1)'(pop);
		end
	end

endmodule

FILE: rtl/osc_back.sv
// back end: reciprocal divider pipeline, offset and scale combine, result queue
module osc_back import osc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  jq_stat_t jq_stat,
	input  job_t     job,
	output logic     job_pop,
	input  logic     pop,
	output logic     empty,
	output res_t     result
);

	localparam logic [1:0] LAST_IDX_GYRO = 2'd2;
	localparam logic [1:0] LAST_IDX_ACC  = 2'd1;

	typedef struct packed {
		logic       kind;
		logic [1:0] axis;
		logic       neg;
		logic       last;
	} meta_t;

	// job sequencer
	logic       busy_q, iss_q, iss_last;
	logic [1:0] idx_q;
	job_t       jobr_q;
	logic       start;

	// divider pipeline
	logic                    v_s1, v_s2, v_s3, v_s4;
	meta_t                   m_s1, m_s2, m_s3, m_s4, m_iss;
	logic [SUM_W-1:0]        mag_s1, mag_s2, mag_iss;
	logic [PROD_W-1:0]       prod_s2;
	logic [SUM_W-1:0]        q0_s3, q0;
	logic                    ge_s3;
	logic [SUM_W-1:0]        qmag;
	logic signed [QW-1:0]    qm, q_s4;
	logic signed [SUM_W-1:0] sel;

	// combine
	logic signed [QW-1:0] a1_q;
	logic signed [QW:0]   hs, hd, hs_c, hd_c;

	// result queue
	res_t              rmem [RES_DEPTH];
	logic [RES_AW-1:0] rwr_q, rrd_q;
	logic [RES_AW:0]   rcnt_q;
	logic              res_we, res_rd;
	res_t              res_din;

	assign start   = !busy_q && !jq_stat.empty &&
		(rcnt_q <= (RES_AW+1)'(RES_DEPTH - MAX_RES));
	assign job_pop = start;

	assign iss_last = (idx_q == ((jobr_q.kind == KIND_ACC) ? LAST_IDX_ACC : LAST_IDX_GYRO));

	always_comb begin
		unique case (idx_q)
			2'd0:    sel = jobr_q.sum0;
			2'd1:    sel = jobr_q.sum1;
			default: sel = jobr_q.sum2;
		endcase
	end

	assign mag_iss    = sel[SUM_W-1] ? SUM_W'(-sel) : SUM_W'(sel);
	assign m_iss.kind = jobr_q.kind;
	assign m_iss.axis = (jobr_q.kind == KIND_GYRO) ? idx_q : jobr_q.axis;
	assign m_iss.neg  = sel[SUM_W-1];
	assign m_iss.last = iss_last;

	assign q0   = prod_s2[DIV_SHIFT +: SUM_W];
	assign qmag = q0_s3 + SUM_W'(ge_s3);
	assign qm   = qmag[QW-1:0];

	// halving toward zero: add one before the shift when negative
	assign hs   = {a1_q[QW-1], a1_q} + {q_s4[QW-1], q_s4};
	assign hd   = {a1_q[QW-1], a1_q} - {q_s4[QW-1], q_s4};
	assign hs_c = hs + {{QW{1'b0}}, hs[QW]};
	assign hd_c = hd + {{QW{1'b0}}, hd[QW]};

	always_comb begin
		res_we  = 1'b0;
		res_din = '{result_kind: KIND_GYRO, axis: m_s4.axis, offset: q_s4[SMP_W-1:0],
			scale: '0, last: m_s4.last};
		if (v_s4) begin
			if (m_s4.kind == KIND_GYRO) begin
				res_we = 1'b1;
			end else if (m_s4.last) begin
				res_we              = 1'b1;
				res_din.result_kind = KIND_ACC;
				res_din.offset      = hs_c[SMP_W:1];
				res_din.scale       = hd_c[SMP_W:1];
			end
		end
	end

	assign res_rd = pop && (rcnt_q != '0);
	assign empty  = (rcnt_q == '0);
	assign result = rmem[rrd_q];

	always_ff @(posedge clk) begin
		if (start) jobr_q <= job;
		mag_s1  <= mag_iss;
		m_s1    <= m_iss;
		prod_s2 <= mag_s1 * RECIP;
		mag_s2  <= mag_s1;
		m_s2    <= m_s1;
		q0_s3   <= q0;
		ge_s3   <= ((mag_s2 - (q0 * SAMPLES_SUM)) >= SAMPLES_SUM);
		m_s3    <= m_s2;
		q_s4    <= m_s3.neg ? -qm : qm;
		m_s4    <= m_s3;
		if (v_s4 && (m_s4.kind == KIND_ACC) && !m_s4.last) a1_q <= q_s4;
		if (res_we) rmem[rwr_q] <= res_din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			iss_q  <= 1'b0;
			idx_q  <= '0;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			rwr_q  <= '0;
			rrd_q  <= '0;
			rcnt_q <= '0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				iss_q  <= 1'b1;
				idx_q  <= '0;
			end else begin
				if (iss_q) begin
					if (iss_last) iss_q <= 1'b0;
					else          idx_q <= idx_q + 1'b1;
				end
				if (v_s4 && m_s4.last) busy_q <= 1'b0;
			end
			v_s1 <= iss_q;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			if (res_we) rwr_q <= rwr_q + 1'b1;
			if (res_rd) rrd_q <= rrd_q + 1'b1;
			rcnt_q <= rcnt_q + (RES_AW+1)'(res_we) - (RES_AW+1)'(res_rd);
		end
	end

endmodule

FILE: rtl/imu_offset_scale_calibrator.sv
// top level of the imu offset and scale calibrator
//
//  channel  | handshake        | word
//  ---------+------------------+--------------------------------------------
//  sample   | push / full      | button_pressed, sample_x, sample_y, sample_z
//  result   | empty / pop      | result_kind, axis, offset, scale, last
//  config   | cfg_we           | cfg_wdata (cal_target)
//
// one sample word per cycle is taken while full is low; accumulation is one add per axis
// a finished run hands its sums to a two-entry job queue; full follows that queue
// the back end runs one job at a time through a four-stage divider, which does three
// divisions for a gyro job and two for an accel job
// results wait in a four-entry queue; a job starts only with room for three results
// reset clears all control state at once; a config write restarts the sequence
`include "imu_offset_scale_calibrator_macros.svh"

module imu_offset_scale_calibrator import osc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  in_t  sample,
	output logic empty,
	input  logic pop,
	output res_t result,
	input  logic cfg_we,
	input  logic cfg_wdata
);

	// front to job queue
	logic     job_push;
	job_t     job_in;

	// job queue to back
	logic     job_pop;
	job_t     job_out;
	jq_stat_t jq_stat;

	// sequencer and accumulators, stalls only on a full job queue
	osc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.sample    (sample),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.jq_stat   (jq_stat),
		.job_push  (job_push),
		.job       (job_in)
	);

	// decouples accumulation from division
	osc_jobq u_jobq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.din    (job_in),
		.pop    (job_pop),
		.dout   (job_out),
		.stat   (jq_stat)
	);

	// divide, combine and queue the result words
	osc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.jq_stat (jq_stat),
		.job     (job_out),
		.job_pop (job_pop),
		.pop     (pop),
		.empty   (empty),
		.result  (result)
	);

	// a job is never handed over to a full queue, nor taken from an empty one
	`OSC_ASSERT_NOW(a_jobq_no_overflow, job_push, !jq_stat.full, "job pushed into full queue")
	`OSC_ASSERT_NOW(a_jobq_no_underflow, job_pop, !jq_stat.empty, "job popped from empty queue")

	// an accelerometer result is always the only word of its job
	`OSC_ASSERT_NOW(a_acc_last, !empty && (result.result_kind == KIND_ACC), result.last,
		"accelerometer result without last")

	// a gyro result carries last exactly on the z axis
	`OSC_ASSERT_NOW(a_gyro_last, !empty && (result.result_kind == KIND_GYRO),
		result.last == (result.axis == AXIS_Z), "gyro last flag off the z axis")

	// a config write with an empty job queue leaves the front accepting words
	`OSC_ASSERT_NEXT(a_cfg_clears, cfg_we && jq_stat.empty, !full, "front stalled after config")

endmodule

FILE: tb/tb_imu_offset_scale_calibrator.sv
// self-checking testbench for the imu offset and scale calibrator
module tb_imu_offset_scale_calibrator;
	import osc_pkg::*;

	// cal_target settings
	localparam logic CAL_GYRO = 1'b0;
	localparam logic CAL_ACC  = 1'b1;

	// sequence positions shared by both modes, plus the gyro-only ones
	localparam logic [3:0] PH_START     = 4'd0;
	localparam logic [3:0] PH_GYRO_SUM  = 4'd1;
	localparam logic [3:0] PH_GYRO_EMIT = 4'd2;

	// how the samples of one accumulation stretch are chosen
	localparam int STY_RANDOM = 0;
	localparam int STY_MAX    = 1;
	localparam int STY_MIN    = 2;
	localparam int STY_BIAS   = 3;
	localparam int STY_ALT    = 4;

	localparam int NO_CUT      = 3;     // axis index meaning the run is not aborted
	localparam int SETTLE      = 32;    // back end drains a job in well under this
	localparam int HOLD_CYCLES = 7000;  // long result stall, outlasts four gyro runs
	localparam int STALL_LIMIT = 20000; // cycles with no word moving on either side
	localparam int RESULT_GOAL = 36;    // results wanted from the random part

	// expected behavior of the calibrator and the store of results still owed
	class cal_scoreboard;
		logic                    cal_target;
		logic [3:0]              phase;
		logic [CNT_W-1:0]        count;
		logic signed [SUM_W-1:0] sums [3];
		res_t                    owed_q [$];
		int                      errors;
		int                      produced;

		function new();
			errors   = 0;
			produced = 0;
			set_target(CAL_GYRO);
		endfunction

		function void clear_run();
			count = '0;
			foreach (sums[i])
				sums[i] = '0;
		endfunction

		// a register write restarts the whole sequence
		function void set_target(logic mode);
			cal_target = mode;
			phase      = PH_START;
			clear_run();
		endfunction

		function void owe(logic kind, logic [1:0] ax, int offset, int scale, logic last);
			res_t r;
			r.result_kind = kind;
			r.axis        = ax;
			r.offset      = SMP_W'(offset);
			r.scale       = SMP_W'(scale);
			r.last        = last;
			owed_q.push_back(r);
			produced++;
		endfunction

		function void note_word(in_t w);
			logic signed [SMP_W-1:0] s [3];
			logic [1:0]              ax;
			int                      a1;
			int                      a2;
			s[0] = w.sample_x;
			s[1] = w.sample_y;
			s[2] = w.sample_z;
			ax   = phase[3:2];
			if (cal_target == CAL_GYRO) begin
				case (phase)
					PH_START: begin
						if (w.button_pressed) begin
							clear_run();
							phase = PH_GYRO_SUM;
						end
					end
					PH_GYRO_SUM: begin
						foreach (sums[k])
							sums[k] = sums[k] + s[k];
						count = count + 1'b1;
						if (count == SAMPLES_CNT)
							phase = PH_GYRO_EMIT;
					end
					PH_GYRO_EMIT: begin
						// emitted on whatever word follows the last sample
						for (int k = 0; k < 3; k++)
							owe(KIND_GYRO, 2'(k), int'(sums[k]) / SAMPLES, 0, k == 2);
						clear_run();
						phase = PH_START;
					end
					default: phase = PH_START;
				endcase
			end else if (ax > AXIS_Z) begin
				phase = PH_START;
			end else begin
				case (step_t'({1'b0, phase[1:0]}))
					ST_WAIT1: begin
						if (w.button_pressed) begin
							clear_run();
							phase = phase + 4'd1;
						end
					end
					ST_WAIT2: begin
						if (w.button_pressed)
							phase = phase + 4'd1;
					end
					ST_SUM1: begin
						sums[0] = sums[0] + s[ax];
						count   = count + 1'b1;
						if (count == SAMPLES_CNT) begin
							count = '0;
							phase = phase + 4'd1;
						end
					end
					default: begin
						sums[1] = sums[1] + s[ax];
						count   = count + 1'b1;
						if (count == SAMPLES_CNT) begin
							// both averages truncate before they are combined
							a1 = int'(sums[0]) / SAMPLES;
							a2 = int'(sums[1]) / SAMPLES;
							owe(KIND_ACC, ax, (a1 + a2) / 2, (a1 - a2) / 2, 1'b1);
							count = '0;
							phase = (ax == AXIS_Z) ? PH_START : phase + 4'd1;
						end
					end
				endcase
			end
		endfunction

		function void field_ok(string name, logic signed [SMP_W:0] want,
				logic signed [SMP_W:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (owed_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual axis %0d offset %0d",
					$time, got.axis, got.offset);
				errors++;
				return;
			end
			want = owed_q.pop_front();
			field_ok("result_kind", want.result_kind, got.result_kind);
			field_ok("axis", want.axis, got.axis);
			field_ok("offset", want.offset, got.offset);
			field_ok("scale", want.scale, got.scale);
			field_ok("last", want.last, got.last);
		endfunction

		function int pending();
			return owed_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	in_t  sample;
	logic empty;
	logic pop;
	res_t result;
	logic cfg_we;
	logic cfg_wdata;

	cal_scoreboard           sb;
	bit                      idle_ok = 1'b1;  // random idle bursts allowed
	bit                      hold_go = 1'b0;  // asks the result side for a long stall
	int                      stall_cycles = 0;
	logic signed [SMP_W-1:0] bias [3];

	imu_offset_scale_calibrator uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.sample    (sample),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// sample value for one axis of one word
	function automatic logic signed [SMP_W-1:0] pick_sample(int style, int ax, int idx);
		case (style)
			STY_MAX:  return {1'b0, {(SMP_W-1){1'b1}}};
			STY_MIN:  return {1'b1, {(SMP_W-1){1'b0}}};
			STY_BIAS: return SMP_W'(int'(bias[ax]) + int'($urandom_range(0, 63)) - 32);
			STY_ALT:  return idx[0] ? {1'b0, {(SMP_W-1){1'b1}}} : {1'b1, {(SMP_W-1){1'b0}}};
			default:  return SMP_W'($urandom);
		endcase
	endfunction

	function automatic in_t make_word(logic press, int style, int idx);
		in_t w;
		w.button_pressed = press;
		w.sample_x       = pick_sample(style, 0, idx);
		w.sample_y       = pick_sample(style, 1, idx);
		w.sample_z       = pick_sample(style, 2, idx);
		return w;
	endfunction

	// offer one sample word, with an occasional idle burst ahead of it
	task automatic send_word(input in_t w);
		if (idle_ok && $urandom_range(0, 7) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		push   <= 1'b1;
		sample <= w;
		@(posedge clk);
		while (full)
			@(posedge clk);
		sb.note_word(w);
	endtask

	// words with the button up: ignored while waiting for a press
	task automatic send_idle(input int n);
		for (int i = 0; i < n; i++)
			send_word(make_word(1'b0, STY_RANDOM, i));
	endtask

	// one accumulation stretch; the button is don't-care here
	task automatic send_sum(input int n, input int style);
		foreach (bias[i])
			bias[i] = SMP_W'($urandom);
		for (int i = 0; i < n; i++)
			send_word(make_word(1'($urandom_range(0, 1)), style, i));
	endtask

	task automatic wait_drained();
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// stop offering, let the back end go quiet, then write cal_target
	task automatic restart(input logic mode);
		push <= 1'b0;
		wait_drained();
		repeat (SETTLE) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= mode;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_target(mode);
	endtask

	// press, SAMPLES samples, then the word that triggers the three offsets;
	// a cut below SAMPLES aborts the run with a register write instead
	task automatic gyro_run(input int style, input int cut);
		send_idle($urandom_range(0, 3));
		send_word(make_word(1'b1, STY_RANDOM, 0));
		if (cut < SAMPLES) begin
			send_sum(cut, style);
			restart(CAL_GYRO);
		end else begin
			send_sum(SAMPLES, style);
			send_word(make_word(1'($urandom_range(0, 1)), STY_RANDOM, 0));
		end
	endtask

	// x, y, z in turn, two orientations each; negative style means random per stretch,
	// cut counts samples into the cut axis at which the run is aborted
	task automatic accel_run(input int s1, input int s2, input int cut_axis, input int cut);
		int st;
		for (int ax = 0; ax < 3; ax++) begin
			send_idle($urandom_range(0, 3));
			send_word(make_word(1'b1, STY_RANDOM, 0));
			st = (s1 < 0) ? $urandom_range(STY_RANDOM, STY_ALT) : s1;
			if (ax == cut_axis && cut < SAMPLES) begin
				send_sum(cut, st);
				restart(CAL_ACC);
				return;
			end
			send_sum(SAMPLES, st);
			// presses are only taken in the wait step, so idle words go first
			send_idle($urandom_range(0, 3));
			send_word(make_word(1'b1, STY_RANDOM, 0));
			st = (s2 < 0) ? $urandom_range(STY_RANDOM, STY_ALT) : s2;
			if (ax == cut_axis) begin
				send_sum(cut - SAMPLES, st);
				restart(CAL_ACC);
				return;
			end
			send_sum(SAMPLES, st);
		end
	endtask

	// result side: check every accepted word, idle in bursts, or stall on request
	initial begin
		int hold_cnt;
		int sink_gap;
		hold_cnt = 0;
		sink_gap = 0;
		pop <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (pop && !empty)
				sb.check_result(result);
			if (hold_go) begin
				hold_cnt = HOLD_CYCLES;
				hold_go  = 1'b0;
			end
			if (sink_gap == 0 && idle_ok && $urandom_range(0, 5) == 0)
				sink_gap = $urandom_range(1, 3);
			if (hold_cnt > 0) begin
				hold_cnt--;
				pop <= 1'b0;
			end else if (sink_gap > 0) begin
				sink_gap--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// watchdog: no word moving on either side for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		int  goal;
		bit  cut;
		logic mode;
		sb = new();
		arst_n    <= 1'b0;
		push      <= 1'b0;
		sample    <= '0;
		cfg_we    <= 1'b0;
		cfg_wdata <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// field extremes while the reset mode waits for a press
		send_word(make_word(1'b0, STY_MAX, 0));
		send_word(make_word(1'b0, STY_MIN, 0));
		send_word(in_t'('0));
		send_word('{button_pressed: 1'b0, sample_x: '1, sample_y: '1, sample_z: '1});

		// both register values, back to back
		restart(CAL_ACC);
		restart(CAL_GYRO);

		// gyro runs with sums at both extremes, then a random one
		gyro_run(STY_MAX, SAMPLES);
		gyro_run(STY_MIN, SAMPLES);
		gyro_run(STY_RANDOM, SAMPLES);

		// results stall for a long stretch while runs keep coming, so the
		// result and job queues fill and full pushes back on the sample side
		hold_go = 1'b1;
		repeat (4)
			gyro_run($urandom_range(STY_RANDOM, STY_ALT), SAMPLES);
		send_idle(20);
		push <= 1'b0;
		wait_drained();

		// accelerometer with opposite extreme orientations: widest span
		restart(CAL_ACC);
		accel_run(STY_MAX, STY_MIN, NO_CUT, 0);
		accel_run(STY_MIN, STY_MAX, NO_CUT, 0);

		// random phases: mode, run count, content and aborts all drawn at random
		goal = sb.produced + RESULT_GOAL;
		while (sb.produced < goal) begin
			mode = ($urandom_range(0, 2) == 0) ? CAL_ACC : CAL_GYRO;
			restart(mode);
			repeat ($urandom_range(1, 3)) begin
				cut = ($urandom_range(0, 4) == 0);
				if (mode == CAL_GYRO)
					gyro_run($urandom_range(STY_RANDOM, STY_ALT),
						cut ? $urandom_range(0, SAMPLES - 1) : SAMPLES);
				else
					accel_run(-1, -1, cut ? $urandom_range(0, 2) : NO_CUT,
						$urandom_range(0, 2 * SAMPLES - 1));
			end
		end

		// closing stretch at full rate on both sides
		idle_ok = 1'b0;
		restart(CAL_GYRO);
		gyro_run(STY_RANDOM, SAMPLES);
		gyro_run(STY_BIAS, SAMPLES);

		push <= 1'b0;
		wait_drained();
		repeat (SETTLE) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
